// File: design/dal_pkg.sv
// Shared constants, codes and types for the dense array list.
`default_nettype none
package dal_pkg;

   localparam int LIST_DEPTH = 128;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 8;
   localparam int COUNT_OUT_W = 8;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // Read tree: cells are ORed in groups, one register per group.
   localparam int RD_GROUP   = 16;
   localparam int NUM_GROUPS = (LIST_DEPTH + RD_GROUP - 1) / RD_GROUP;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_POS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

   // Command broadcast to every cell in the cycle an item is accepted.
   typedef struct packed {
      cell_op_type              op;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] value;
      logic                     rd_en;
   } cell_cmd_type;

endpackage
`default_nettype wire

// File: design/dal_cell.sv
// One slot of the list: holds an entry and hands it down to its lower neighbor.
`default_nettype none
module dal_cell
   import dal_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [IDX_W-1:0]         my_index,
   input  wire cell_cmd_type             cmd,
   input  wire logic signed [DATA_W-1:0] next_data,
   output logic signed [DATA_W-1:0]      data_out,
   output logic signed [DATA_W-1:0]      rd_data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     hit;

   assign hit = (cmd.idx == my_index);

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         OP_LOAD: begin
            if (hit) data_in = cmd.value;
         end
         // Every cell at or above the removed slot takes its upper neighbor.
         OP_REMOVE: begin
            if (my_index >= cmd.idx) data_in = next_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;
   assign rd_data  = (cmd.rd_en && hit) ? data_ff : '0;

endmodule
`default_nettype wire

// File: design/dal_read_tree.sv
// Registered OR tree that gathers the one selected cell's read data.
`default_nettype none
module dal_read_tree
   import dal_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire logic signed [DATA_W-1:0] cell_rd [LIST_DEPTH],
   output logic signed [DATA_W-1:0]      rd_value
);

   logic signed [DATA_W-1:0] group_ff [NUM_GROUPS];
   logic signed [DATA_W-1:0] group_in [NUM_GROUPS];

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < RD_GROUP; k++) begin
            if (g * RD_GROUP + k < LIST_DEPTH) begin
               group_in[g] = group_in[g] | cell_rd[g * RD_GROUP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   always_comb begin
      rd_value = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         rd_value = rd_value | group_ff[g];
      end
   end

endmodule
`default_nettype wire

// File: design/dal_ctrl.sv
// Decodes each accepted word into a cell command and keeps the entry count.
`default_nettype none
module dal_ctrl
   import dal_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [1:0]               mode,
   input  wire logic [POS_W-1:0]         position,
   input  wire logic signed [DATA_W-1:0] value,
   output cell_cmd_type                  cmd,
   output logic [CNT_W-1:0]              count_next,
   output status_type                    status
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] idx_wide;
   logic             full;
   logic             pos_bad;
   logic             in_list;
   logic             val_nz;

   assign full     = (count_ff == CNT_W'(LIST_DEPTH));
   assign pos_bad  = (position == '0) || (CMP_W'(position) > CMP_W'(LIST_DEPTH));
   assign idx_wide = CMP_W'(position) - CMP_W'(1);
   assign in_list  = (idx_wide < CMP_W'(count_ff));
   assign val_nz   = (value != '0);

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.idx   = IDX_W'(idx_wide);
      cmd.value = value;
      cmd.rd_en = 1'b0;
      count_in  = count_ff;
      status    = ST_OK;
      case (mode_type'(mode))
         MODE_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else if (val_nz) begin
               cmd.op   = OP_LOAD;
               cmd.idx  = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_WRITE: begin
            if (pos_bad) begin
               status = ST_BAD_POS;
            end else if (in_list) begin
               if (val_nz) begin
                  cmd.op = OP_LOAD;
               end else begin
                  cmd.op   = OP_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (val_nz && !full) begin
               // Past the end: the value goes after the last entry.
               cmd.op   = OP_LOAD;
               cmd.idx  = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_DELETE: begin
            if (pos_bad) begin
               status = ST_BAD_POS;
            end else if (in_list) begin
               cmd.op   = OP_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_READ: begin
            if (pos_bad) begin
               status = ST_BAD_POS;
            end else begin
               cmd.rd_en = in_list;
            end
         end
         default: status = ST_OK;
      endcase
      if (!accept) begin
         cmd.op    = OP_NONE;
         cmd.rd_en = 1'b0;
         count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_next = count_in;

endmodule
`default_nettype wire

// File: design/dense_array_list.sv
// Dense list of nonzero values kept in a chain of cells, one entry per cell.
// Throughput: one word per cycle while the output is not stalled; the cells and
// the count update in the accept cycle, and the read data passes one registered
// OR stage before the output register.
// Reset (synchronous, active high) clears all entries and the count at once.
`default_nettype none
module dense_array_list
   import dal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [1:0] mode, [9:2] position, [41:10] value, [47:42] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] read_value, [39:32] entry_count, [41:40] status, [47:42] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                     accept;
   logic                     advance;
   cell_cmd_type             cmd;
   logic [CNT_W-1:0]         count_next;
   status_type               status;
   logic signed [DATA_W-1:0] cell_data [LIST_DEPTH];
   logic signed [DATA_W-1:0] cell_next [LIST_DEPTH];
   logic signed [DATA_W-1:0] cell_rd   [LIST_DEPTH];
   logic signed [DATA_W-1:0] rd_value;

   logic                     pend_ff;
   logic                     pend_in;
   logic [CNT_W-1:0]         pend_count_ff;
   status_type               pend_status_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;
   status_type               rsp_status_ff;

   // The pending word moves to the output register whenever that register is free.
   assign advance    = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || advance;
   assign accept     = req_tvalid && req_tready;

   dal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_tdata[1:0]),
      .position   (req_tdata[9:2]),
      .value      (req_tdata[41:10]),
      .cmd        (cmd),
      .count_next (count_next),
      .status     (status)
   );

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      if (i == LIST_DEPTH - 1) begin : g_top
         assign cell_next[i] = '0;
      end else begin : g_mid
         assign cell_next[i] = cell_data[i + 1];
      end
      dal_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .my_index  (IDX_W'(i)),
         .cmd       (cmd),
         .next_data (cell_next[i]),
         .data_out  (cell_data[i]),
         .rd_data   (cell_rd[i])
      );
   end

   dal_read_tree u_read_tree (
      .clock    (clock),
      .load     (accept),
      .cell_rd  (cell_rd),
      .rd_value (rd_value)
   );

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (advance) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_count_ff  <= count_next;
         pend_status_ff <= status;
      end
      if (advance) begin
         rsp_value_ff  <= rd_value;
         rsp_count_ff  <= COUNT_OUT_W'(pend_count_ff);
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_count_ff, rsp_value_ff};

endmodule
`default_nettype wire

// File: tb/tb_dense_array_list.sv
// Self-checking testbench for the dense array list: directed, full-list, stall and random tests.
`timescale 1ns / 100ps
module tb_dense_array_list
   import dal_pkg::*;
;

   localparam int LONG_STALL  = 240;
   localparam int RANDOM_ITEMS = 1600;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      status_type               status;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic signed [DATA_W-1:0] read_value;
   } list_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [1:0] mode, [9:2] position, [41:10] value, [47:42] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] read_value, [39:32] entry_count, [41:40] status, [47:42] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Shadow copy of the list contents and its fill level.
   logic signed [DATA_W-1:0] shadow_entries [LIST_DEPTH];
   int                       shadow_count = 0;
   list_result_type          results_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int stall_req     = 0;
   int stall_ack     = 0;
   int stall_left    = 0;

   dense_array_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
   end

   // Removes the entry at a 0-based index and closes the gap.
   task automatic remove_shadow_entry(input int idx);
      if (idx < shadow_count) begin
         for (int i = idx; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
         shadow_entries[shadow_count - 1] = '0;
         shadow_count--;
      end
   endtask

   task automatic push_shadow_entry(input logic signed [DATA_W-1:0] v, output bit ok);
      ok = (shadow_count < LIST_DEPTH);
      if (ok && v != 0) begin
         shadow_entries[shadow_count] = v;
         shadow_count++;
      end
   endtask

   // Applies one accepted operation to the shadow list and queues its result.
   task automatic predict_list_op(input mode_type m, input logic [POS_W-1:0] p,
                                  input logic signed [DATA_W-1:0] v);
      list_result_type r;
      bit              ok;
      int              idx;
      r.read_value = '0;
      r.status     = ST_OK;
      idx          = int'(p) - 1;
      if (m == MODE_APPEND) begin
         push_shadow_entry(v, ok);
         if (!ok) r.status = ST_FULL;
      end else if (p == 0 || p > LIST_DEPTH) begin
         r.status = ST_BAD_POS;
      end else if (m == MODE_WRITE) begin
         if (idx < shadow_count) begin
            if (v != 0) shadow_entries[idx] = v;
            else remove_shadow_entry(idx);
         end else begin
            push_shadow_entry(v, ok);
         end
      end else if (m == MODE_DELETE) begin
         remove_shadow_entry(idx);
      end else begin
         r.read_value = (idx < shadow_count) ? shadow_entries[idx] : '0;
      end
      r.entry_count = shadow_count[COUNT_OUT_W-1:0];
      results_due.push_back(r);
   endtask

   // Offers one word, holds it until accepted, then predicts its result.
   task automatic send_op(input mode_type m, input int p, input logic signed [DATA_W-1:0] v);
      logic [POS_W-1:0] pos;
      pos = p[POS_W-1:0];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, v, pos, m};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_list_op(m, pos, v);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic report_mismatch(input list_result_type want, input list_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display({"mismatch: expected value=%0d count=%0d status=%0d, ",
                   "got value=%0d count=%0d status=%0d"},
                  want.read_value, want.entry_count, want.status,
                  got.read_value, got.entry_count, got.status);
   endtask

   task automatic check_result();
      list_result_type got;
      list_result_type want;
      got = list_result_type'(rsp_tdata[41:0]);
      if (results_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("unexpected result word: value=%0d count=%0d status=%0d",
                     got.read_value, got.entry_count, got.status);
      end else begin
         want = results_due.pop_front();
         if (got.read_value !== want.read_value || got.entry_count !== want.entry_count ||
             got.status !== want.status)
            report_mismatch(want, got);
      end
   endtask

   // Receiver: random back-pressure, plus a long hold-off on request.
   always @(posedge clock) begin
      if (stall_req != stall_ack) begin
         stall_ack  <= stall_req;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (rsp_tvalid && rsp_tready) check_result();
   end

   task automatic test_directed();
      send_op(MODE_READ, 1, 0);
      send_op(MODE_DELETE, 1, 0);
      send_op(MODE_APPEND, 0, 0);
      send_op(MODE_WRITE, 0, 5);
      send_op(MODE_READ, LIST_DEPTH + 1, 0);
      send_op(MODE_DELETE, 255, 0);
      send_op(MODE_APPEND, 0, 32'sh7fffffff);
      send_op(MODE_APPEND, 255, 32'sh80000000);
      send_op(MODE_APPEND, 0, -1);
      send_op(MODE_APPEND, 0, 1);
      send_op(MODE_WRITE, 2, 32'sh12345678);
      send_op(MODE_WRITE, 10, 0);
      send_op(MODE_WRITE, 100, 32'shdeadbeef);
      send_op(MODE_READ, 5, 0);
      send_op(MODE_DELETE, 2, 0);
      send_op(MODE_READ, 2, 0);
      send_op(MODE_WRITE, 1, 0);
      send_op(MODE_DELETE, 50, 0);
      send_op(MODE_READ, LIST_DEPTH, 0);
      send_op(MODE_READ, 0, 0);
      send_op(MODE_WRITE, LIST_DEPTH, 7);
      send_op(MODE_READ, 1, 0);
      wait_results_done();
   endtask

   task automatic test_full_list();
      while (shadow_count < LIST_DEPTH) send_op(MODE_APPEND, 0, $urandom | 1);
      send_op(MODE_APPEND, 0, 32'sh55);
      send_op(MODE_APPEND, 0, 0);
      send_op(MODE_WRITE, LIST_DEPTH, 32'sha5a5a5a5);
      send_op(MODE_READ, LIST_DEPTH, 0);
      send_op(MODE_DELETE, 1, 0);
      send_op(MODE_READ, 1, 0);
      send_op(MODE_DELETE, LIST_DEPTH, 0);
      send_op(MODE_WRITE, LIST_DEPTH, -5);
      send_op(MODE_READ, LIST_DEPTH, 0);
      // Empty the list from random positions, reading back after each delete.
      while (shadow_count > 0) begin
         send_op(MODE_DELETE, $urandom_range(shadow_count, 1), 0);
         send_op(MODE_READ, $urandom_range(shadow_count + 1, 1), 0);
      end
      wait_results_done();
   endtask

   task automatic test_output_stall();
      send_idle_pct = 0;
      stall_req <= stall_req + 1;
      for (int i = 0; i < 60; i++) send_op(MODE_APPEND, 0, $urandom);
      wait_results_done();
   endtask

   task automatic send_random_op(input int grow_pct);
      mode_type                 m;
      int                       p;
      int                       r;
      logic signed [DATA_W-1:0] v;
      if ($urandom_range(99) < grow_pct) m = MODE_APPEND;
      else begin
         case ($urandom_range(2))
            0: m = MODE_WRITE;
            1: m = MODE_DELETE;
            default: m = MODE_READ;
         endcase
      end
      r = $urandom_range(99);
      if (r < 6) p = 0;
      else if (r < 12) p = $urandom_range(255, LIST_DEPTH + 1);
      else if (r < 16) p = ($urandom_range(1) != 0) ? LIST_DEPTH : 1;
      else p = $urandom_range((shadow_count + 2 > LIST_DEPTH) ? LIST_DEPTH : shadow_count + 2, 1);
      r = $urandom_range(99);
      if (r < 8) v = 0;
      else if (r < 14) begin
         case ($urandom_range(3))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = -1;
            default: v = 1;
         endcase
      end else v = $urandom;
      send_op(m, p, v);
   endtask

   task automatic test_random();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 30;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Alternate stretches that fill the list and stretches that drain it.
         send_random_op(((i / 250) % 2 == 0) ? 55 : 15);
      end
      wait_results_done();
   endtask

   initial begin
      send_idle_pct = 30;
      recv_idle_pct = 65;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_output_stall();
      send_idle_pct = 30;
      recv_idle_pct = 65;
      test_random();
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Verification failed");
      $finish;
   end

endmodule
